@@ rtl/rgb_box_blur_unsharp_mask_unit_macros.svh @@
// ----------------------------------------------------------------------------
// RGB unsharp mask unit: assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RGB_BOX_BLUR_UNSHARP_MASK_UNIT_MACROS_SVH
`define RGB_BOX_BLUR_UNSHARP_MASK_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RBUM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbum: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define RBUM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbum: next-cycle check failed");

`endif

@@ rtl/rbum_pkg.sv @@
// ----------------------------------------------------------------------------
// RGB unsharp mask unit: package
// Widths, constants and shared types of the sharpening pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rbum_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int MIN_DIM    = 4;

  localparam int CFG_W   = 12;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int DIM_W   = COL_W + 1;
  localparam int ROW_W   = $clog2(MAX_HEIGHT + 2);
  localparam int OROW_W  = $clog2(MAX_HEIGHT);

  localparam int PIX_W   = 8;
  localparam int NUM_CH  = 3;
  localparam int RGB_W   = PIX_W * NUM_CH;
  localparam int PIX_MAX = (1 << PIX_W) - 1;

  localparam int FRAC_BITS = 8;
  localparam int GAIN_W    = CFG_W;
  localparam int SUM_W     = PIX_W + 4;
  localparam int RECIP_W   = 13;
  localparam int DIV9_SHIFT = 16;
  localparam logic [RECIP_W-1:0] DIV9_RECIP = RECIP_W'(((1 << DIV9_SHIFT) + 8) / 9);
  localparam int MUL9_W    = SUM_W + RECIP_W;
  localparam int DIFF_W    = PIX_W + 1;
  localparam int PROD_W    = GAIN_W + 1 + DIFF_W;
  localparam int T_W       = PROD_W + 1;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH    = CFG_W'(640);
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT   = CFG_W'(480);
  localparam logic [CFG_W-1:0] RST_SHARPEN_AMOUNT = CFG_W'(307);

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_SHARPEN_AMOUNT = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef logic [RGB_W-1:0] rgb_t;

  // Indexed [column][row], column 2 is the newest.
  typedef rgb_t [2:0][2:0] window_t;

  typedef struct packed {
    logic valid;
    logic border;
    logic last;
  } tag_t;

endpackage

`default_nettype wire

@@ rtl/rbum_line_window.sv @@
// ----------------------------------------------------------------------------
// RGB unsharp mask unit: line stores and 3x3 window
// Two line memories feed the newest window column for every pixel step.
// ----------------------------------------------------------------------------
`default_nettype none

module rbum_line_window (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               push_i,
  input  wire logic [rbum_pkg::COL_W-1:0] col_i,
  input  wire rbum_pkg::rgb_t     pix_i,
  input  wire rbum_pkg::tag_t     tag_i,
  output rbum_pkg::window_t       win_o,
  output rbum_pkg::tag_t          tag_o
);

  rbum_pkg::rgb_t upper_mem [rbum_pkg::MAX_WIDTH];
  rbum_pkg::rgb_t middle_mem [rbum_pkg::MAX_WIDTH];

  rbum_pkg::rgb_t up_rd_q, mid_rd_q;
  logic           s1_valid_q;
  logic [rbum_pkg::COL_W-1:0] s1_col_q;
  rbum_pkg::rgb_t s1_pix_q;
  rbum_pkg::tag_t s1_tag_q;
  logic           byp_q;
  rbum_pkg::rgb_t byp_up_q, byp_mid_q;
  rbum_pkg::window_t win_q;
  rbum_pkg::tag_t win_tag_q;

  rbum_pkg::rgb_t up_s1, mid_s1;
  logic           wr_en;
  logic           rd_en;

  // A read issued while the previous step writes the same column sees stale data.
  assign up_s1  = byp_q ? byp_up_q  : up_rd_q;
  assign mid_s1 = byp_q ? byp_mid_q : mid_rd_q;
  assign wr_en  = en_i && s1_valid_q;
  assign rd_en  = en_i && push_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      upper_mem[s1_col_q]  <= mid_s1;
      middle_mem[s1_col_q] <= s1_pix_q;
    end
    if (rd_en) begin
      up_rd_q  <= upper_mem[col_i];
      mid_rd_q <= middle_mem[col_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      win_tag_q  <= '0;
    end else if (en_i) begin
      s1_valid_q <= push_i;
      win_tag_q  <= s1_valid_q ? s1_tag_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_col_q  <= col_i;
      s1_pix_q  <= pix_i;
      s1_tag_q  <= tag_i;
      byp_q     <= s1_valid_q && (s1_col_q == col_i);
      byp_up_q  <= mid_s1;
      byp_mid_q <= s1_pix_q;
    end
    if (wr_en) begin
      win_q[0]    <= win_q[1];
      win_q[1]    <= win_q[2];
      win_q[2][0] <= up_s1;
      win_q[2][1] <= mid_s1;
      win_q[2][2] <= s1_pix_q;
    end
  end

  assign win_o = win_q;
  assign tag_o = win_tag_q;

endmodule

`default_nettype wire

@@ rtl/rbum_sharpen_pipe.sv @@
// ----------------------------------------------------------------------------
// RGB unsharp mask unit: sharpening pipeline
// Box sum, division by nine, gain multiply, then floor and clamp per channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rbum_sharpen_pipe (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire rbum_pkg::window_t  win_i,
  input  wire rbum_pkg::tag_t     tag_i,
  input  wire logic [rbum_pkg::GAIN_W-1:0] amount_i,
  output logic                    valid_o,
  output rbum_pkg::rgb_t          rgb_o,
  output logic                    last_o
);

  localparam int PW = rbum_pkg::PIX_W;
  localparam int SW = rbum_pkg::SUM_W;
  localparam int NC = rbum_pkg::NUM_CH;

  logic [SW-1:0] sum_d [NC];
  logic [SW-1:0] sum3_q [NC];
  logic [PW-1:0] src3_q [NC];
  rbum_pkg::tag_t tag3_q;

  logic [PW-1:0] blur_d [NC];
  logic [PW-1:0] blur4_q [NC];
  logic [PW-1:0] src4_q [NC];
  rbum_pkg::tag_t tag4_q;

  logic signed [rbum_pkg::PROD_W-1:0] prod_d [NC];
  logic signed [rbum_pkg::PROD_W-1:0] prod5_q [NC];
  logic [PW-1:0] src5_q [NC];
  rbum_pkg::tag_t tag5_q;

  rbum_pkg::rgb_t res_d;
  rbum_pkg::rgb_t res_q;
  logic           valid_q;
  logic           last_q;

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      sum_d[k] = '0;
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          sum_d[k] = sum_d[k] + SW'(win_i[a][b][(NC-1-k)*PW +: PW]);
        end
      end
    end
  end

  always_comb begin
    logic [rbum_pkg::MUL9_W-1:0] m;
    for (int k = 0; k < NC; k++) begin
      m = rbum_pkg::MUL9_W'(sum3_q[k]) * rbum_pkg::MUL9_W'(rbum_pkg::DIV9_RECIP);
      blur_d[k] = tag3_q.border ? src3_q[k] : m[rbum_pkg::DIV9_SHIFT +: PW];
    end
  end

  always_comb begin
    logic signed [rbum_pkg::DIFF_W-1:0] diff;
    logic signed [rbum_pkg::PROD_W-1:0] gain_x;
    logic signed [rbum_pkg::PROD_W-1:0] diff_x;
    gain_x = rbum_pkg::PROD_W'($signed({1'b0, amount_i}));
    for (int k = 0; k < NC; k++) begin
      diff      = $signed({1'b0, src4_q[k]}) - $signed({1'b0, blur4_q[k]});
      diff_x    = rbum_pkg::PROD_W'(diff);
      prod_d[k] = gain_x * diff_x;
    end
  end

  always_comb begin
    logic signed [rbum_pkg::T_W-1:0] t;
    logic [rbum_pkg::T_W-2-rbum_pkg::FRAC_BITS:0] v;
    for (int k = 0; k < NC; k++) begin
      t = $signed(rbum_pkg::T_W'({src5_q[k], {rbum_pkg::FRAC_BITS{1'b0}}}))
        + rbum_pkg::T_W'(prod5_q[k]);
      v = t[rbum_pkg::T_W-2:rbum_pkg::FRAC_BITS];
      if (t[rbum_pkg::T_W-1]) begin
        res_d[(NC-1-k)*PW +: PW] = '0;
      end else if (v > ($bits(v))'(rbum_pkg::PIX_MAX)) begin
        res_d[(NC-1-k)*PW +: PW] = PW'(rbum_pkg::PIX_MAX);
      end else begin
        res_d[(NC-1-k)*PW +: PW] = v[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag3_q  <= '0;
      tag4_q  <= '0;
      tag5_q  <= '0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else if (en_i) begin
      tag3_q  <= tag_i;
      tag4_q  <= tag3_q;
      tag5_q  <= tag4_q;
      valid_q <= tag5_q.valid;
      last_q  <= tag5_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NC; k++) begin
        sum3_q[k]  <= sum_d[k];
        src3_q[k]  <= win_i[1][1][(NC-1-k)*PW +: PW];
        blur4_q[k] <= blur_d[k];
        src4_q[k]  <= src3_q[k];
        prod5_q[k] <= prod_d[k];
        src5_q[k]  <= src4_q[k];
      end
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign rgb_o   = res_q;
  assign last_o  = last_q;

endmodule

`default_nettype wire

@@ rtl/rgb_box_blur_unsharp_mask_unit.sv @@
// ----------------------------------------------------------------------------
// RGB unsharp mask unit: top level
// Streams raster RGB pixels through a 3x3 box blur and sharpens each pixel.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake                 Payload
//   in       sink       in_valid_i / in_stall_o   op_i, red/green/blue_in_i
//   out      source     out_valid_o / out_stall_i red/green/blue_out_o,
//                                                 frame_last_o
//   cfg      sink       cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One word is taken per clock while out_stall_i does not hold a result; each word
// then passes the line memory read and the window, sum, blur, product and output registers.
// Reset clears the counters and the pipeline valid bits; the line memories
// start undefined and need no clearing.
// While a result is held by out_stall_i, the whole pipeline and the input stall.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb_box_blur_unsharp_mask_unit_macros.svh"

module rgb_box_blur_unsharp_mask_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic                       op_i,
  input  wire logic [rbum_pkg::PIX_W-1:0] red_in_i,
  input  wire logic [rbum_pkg::PIX_W-1:0] green_in_i,
  input  wire logic [rbum_pkg::PIX_W-1:0] blue_in_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [rbum_pkg::PIX_W-1:0]      red_out_o,
  output logic [rbum_pkg::PIX_W-1:0]      green_out_o,
  output logic [rbum_pkg::PIX_W-1:0]      blue_out_o,
  output logic                            frame_last_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [1:0]                 cfg_idx_i,
  input  wire logic [rbum_pkg::CFG_W-1:0] cfg_wdata_i
);

  localparam int COL_W  = rbum_pkg::COL_W;
  localparam int DIM_W  = rbum_pkg::DIM_W;
  localparam int ROW_W  = rbum_pkg::ROW_W;
  localparam int OROW_W = rbum_pkg::OROW_W;
  localparam int PW     = rbum_pkg::PIX_W;

  logic [rbum_pkg::CFG_W-1:0] width_q, height_q, amount_q;
  logic [ROW_W-1:0]  in_row_q, in_row_d;
  logic [COL_W-1:0]  in_col_q, in_col_d;
  logic [OROW_W-1:0] out_row_q, out_row_d;
  logic [COL_W-1:0]  out_col_q, out_col_d;

  logic [DIM_W-1:0] w_eff;
  logic [ROW_W-1:0] h_eff;
  logic             en;
  logic             accept;
  logic             complete;
  logic             step;
  logic             restart;
  logic             col_wrap;
  logic             ox_last;
  logic             oy_last;
  rbum_pkg::tag_t   tag;
  rbum_pkg::rgb_t   pix;

  rbum_pkg::window_t win;
  rbum_pkg::tag_t    win_tag;
  logic              res_valid;
  rbum_pkg::rgb_t    res_rgb;
  logic              res_last;

  always_comb begin
    if (width_q == '0) begin
      w_eff = DIM_W'(1);
    end else if (32'(width_q) > rbum_pkg::MAX_WIDTH) begin
      w_eff = DIM_W'(rbum_pkg::MAX_WIDTH);
    end else begin
      w_eff = DIM_W'(width_q);
    end
    if (height_q == '0) begin
      h_eff = ROW_W'(1);
    end else if (32'(height_q) > rbum_pkg::MAX_HEIGHT) begin
      h_eff = ROW_W'(rbum_pkg::MAX_HEIGHT);
    end else begin
      h_eff = ROW_W'(height_q);
    end
  end

  assign en         = !(res_valid && out_stall_i);
  assign in_stall_o = !en;
  assign accept     = in_valid_i && en;
  assign complete   = in_row_q >= h_eff;
  assign step       = accept && !(op_i == rbum_pkg::OP_DRAIN && !complete);
  assign pix        = complete ? '0 : {red_in_i, green_in_i, blue_in_i};

  assign col_wrap = (DIM_W'(in_col_q) + DIM_W'(1)) == w_eff;
  assign ox_last  = (DIM_W'(out_col_q) + DIM_W'(1)) == w_eff;
  assign oy_last  = (ROW_W'(out_row_q) + ROW_W'(1)) == h_eff;

  always_comb begin
    tag.valid  = !(in_row_q == '0 || (in_row_q == ROW_W'(1) && in_col_q == '0));
    tag.border = w_eff < DIM_W'(rbum_pkg::MIN_DIM) || h_eff < ROW_W'(rbum_pkg::MIN_DIM)
              || out_row_q == '0 || out_col_q == '0 || oy_last || ox_last;
    tag.last   = oy_last && ox_last;
  end

  always_comb begin
    in_row_d  = in_row_q;
    in_col_d  = in_col_q;
    out_row_d = out_row_q;
    out_col_d = out_col_q;
    if (step) begin
      if (col_wrap) begin
        in_col_d = '0;
        in_row_d = in_row_q + ROW_W'(1);
      end else begin
        in_col_d = in_col_q + COL_W'(1);
      end
      if (tag.valid) begin
        if (ox_last) begin
          out_col_d = '0;
          out_row_d = out_row_q + OROW_W'(1);
        end else begin
          out_col_d = out_col_q + COL_W'(1);
        end
      end
      if (tag.valid && tag.last) begin
        in_row_d  = '0;
        in_col_d  = '0;
        out_row_d = '0;
        out_col_d = '0;
      end
    end
  end

  always_comb begin
    restart = 1'b0;
    if (cfg_we_i) begin
      case (rbum_pkg::cfg_reg_e'(cfg_idx_i))
        rbum_pkg::REG_FRAME_WIDTH:  restart = 1'b1;
        rbum_pkg::REG_FRAME_HEIGHT: restart = 1'b1;
        default:                    restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rbum_pkg::RST_FRAME_WIDTH;
      height_q <= rbum_pkg::RST_FRAME_HEIGHT;
      amount_q <= rbum_pkg::RST_SHARPEN_AMOUNT;
    end else if (cfg_we_i) begin
      case (rbum_pkg::cfg_reg_e'(cfg_idx_i))
        rbum_pkg::REG_FRAME_WIDTH:    width_q  <= cfg_wdata_i;
        rbum_pkg::REG_FRAME_HEIGHT:   height_q <= cfg_wdata_i;
        rbum_pkg::REG_SHARPEN_AMOUNT: amount_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else if (restart) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else begin
      in_row_q  <= in_row_d;
      in_col_q  <= in_col_d;
      out_row_q <= out_row_d;
      out_col_q <= out_col_d;
    end
  end

  rbum_line_window u_line_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .push_i (step),
    .col_i  (in_col_q),
    .pix_i  (pix),
    .tag_i  (tag),
    .win_o  (win),
    .tag_o  (win_tag)
  );

  rbum_sharpen_pipe u_sharpen_pipe (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .win_i    (win),
    .tag_i    (win_tag),
    .amount_i (amount_q),
    .valid_o  (res_valid),
    .rgb_o    (res_rgb),
    .last_o   (res_last)
  );

  assign out_valid_o  = res_valid;
  assign red_out_o    = res_rgb[2*PW +: PW];
  assign green_out_o  = res_rgb[PW +: PW];
  assign blue_out_o   = res_rgb[0 +: PW];
  assign frame_last_o = res_last;

  `RBUM_ASSERT_IMPL(a_stall_only_when_held, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  `RBUM_ASSERT_IMPL(a_in_col_in_frame, clk_i, rst_ni, 1'b1, DIM_W'(in_col_q) < w_eff)
  `RBUM_ASSERT_IMPL(a_out_col_in_frame, clk_i, rst_ni, 1'b1, DIM_W'(out_col_q) < w_eff)
  `RBUM_ASSERT_NEXT(a_frame_restart, clk_i, rst_ni, step && tag.valid && tag.last, in_row_q == '0 && in_col_q == '0 && out_row_q == '0 && out_col_q == '0)

endmodule

`default_nettype wire

@@ verif/unsharp_result_monitor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Unsharp mask result monitor
// Watches the configuration port and both word channels, predicts every
// sharpened pixel from the accepted input words, and compares each accepted
// output word with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module unsharp_result_monitor
  import rbum_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic             op_i,
  input  logic [PIX_W-1:0] red_i,
  input  logic [PIX_W-1:0] green_i,
  input  logic [PIX_W-1:0] blue_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [PIX_W-1:0] res_red_i,
  input  logic [PIX_W-1:0] res_green_i,
  input  logic [PIX_W-1:0] res_blue_i,
  input  logic             res_last_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  output int               mismatch_cnt_o,
  output int               pending_o
);

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             last;
  } sharp_pixel_t;

  logic [CFG_W-1:0] width_q;
  logic [CFG_W-1:0] height_q;
  logic [CFG_W-1:0] gain_q;
  rgb_t             upper_line [MAX_WIDTH];
  rgb_t             middle_line [MAX_WIDTH];
  window_t          win_q;
  int unsigned      row_q;
  int unsigned      col_q;
  int unsigned      out_idx_q;
  sharp_pixel_t     expected_pixels [$];

  function automatic int unsigned span(logic [CFG_W-1:0] v, int unsigned limit);
    if (v == '0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] sharpen_channel(logic [PIX_W-1:0] src,
                                                      logic [PIX_W-1:0] blur,
                                                      logic [CFG_W-1:0] gain);
    int t;
    t = int'(src) * (1 << FRAC_BITS) + int'(gain) * (int'(src) - int'(blur));
    if (t < 0) return '0;
    if ((t >>> FRAC_BITS) > PIX_MAX) return PIX_W'(PIX_MAX);
    return PIX_W'(t >>> FRAC_BITS);
  endfunction

  task automatic restart_frame();
    row_q = 0;
    col_q = 0;
    out_idx_q = 0;
    win_q = '0;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatch_cnt_o++;
  endtask

  task automatic sharpen_step(logic is_drain, rgb_t in_pix);
    int unsigned w, h, total, pos, c, ox, oy, sum, sh;
    logic complete, border;
    rgb_t pix, up, mid, center;
    logic [PIX_W-1:0] src, blur;
    logic [PIX_W-1:0] chans [3];
    sharp_pixel_t res;
    w = span(width_q, MAX_WIDTH);
    h = span(height_q, MAX_HEIGHT);
    total = w * h;
    pos = row_q * w + col_q;
    complete = row_q >= h;
    if (is_drain && !complete) return;
    pix = complete ? '0 : in_pix;
    c = (col_q < MAX_WIDTH) ? col_q : 0;
    up = upper_line[c];
    mid = middle_line[c];
    upper_line[c] = mid;
    middle_line[c] = pix;
    win_q[0] = win_q[1];
    win_q[1] = win_q[2];
    win_q[2][0] = up;
    win_q[2][1] = mid;
    win_q[2][2] = pix;
    col_q++;
    if (col_q >= w) begin
      col_q = 0;
      row_q++;
    end
    if (pos < w + 1) return;
    oy = out_idx_q / w;
    ox = out_idx_q % w;
    center = win_q[1][1];
    border = w < MIN_DIM || h < MIN_DIM || oy == 0 || ox == 0 ||
             oy + 1 >= h || ox + 1 >= w;
    for (int k = 0; k < NUM_CH; k++) begin
      sh = 16 - 8 * k;
      src = center[sh +: PIX_W];
      blur = src;
      if (!border) begin
        sum = 0;
        for (int a = 0; a < 3; a++) begin
          for (int b = 0; b < 3; b++) begin
            sum += win_q[a][b][sh +: PIX_W];
          end
        end
        blur = PIX_W'(sum / 9);
      end
      chans[k] = sharpen_channel(src, blur, gain_q);
    end
    res.red = chans[0];
    res.green = chans[1];
    res.blue = chans[2];
    res.last = out_idx_q + 1 >= total;
    expected_pixels.push_back(res);
    out_idx_q++;
    if (res.last) restart_frame();
  endtask

  task automatic compare_result();
    sharp_pixel_t want;
    if (expected_pixels.size() == 0) begin
      report_mismatch("output word with nothing expected",
                      {res_red_i, res_green_i, res_blue_i, res_last_i}, 0);
      return;
    end
    want = expected_pixels.pop_front();
    if (res_red_i !== want.red) report_mismatch("red_out", res_red_i, want.red);
    if (res_green_i !== want.green) report_mismatch("green_out", res_green_i, want.green);
    if (res_blue_i !== want.blue) report_mismatch("blue_out", res_blue_i, want.blue);
    if (res_last_i !== want.last) report_mismatch("frame_last", res_last_i, want.last);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q = RST_FRAME_WIDTH;
      height_q = RST_FRAME_HEIGHT;
      gain_q = RST_SHARPEN_AMOUNT;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_line[i] = '0;
        middle_line[i] = '0;
      end
      restart_frame();
      expected_pixels.delete();
      mismatch_cnt_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FRAME_WIDTH: begin
            width_q = cfg_wdata_i;
            restart_frame();
          end
          REG_FRAME_HEIGHT: begin
            height_q = cfg_wdata_i;
            restart_frame();
          end
          REG_SHARPEN_AMOUNT: begin
            gain_q = cfg_wdata_i;
          end
          default: begin
          end
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        sharpen_step(op_i == OP_DRAIN, {red_i, green_i, blue_i});
      end
      if (out_valid_i && !out_stall_i) compare_result();
      pending_o = expected_pixels.size();
    end
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB unsharp mask unit testbench
// Drives frames of raster pixels with drain words, configuration changes and
// random idling on both channels; the result monitor predicts and checks
// every output word, and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb;
  import rbum_pkg::*;

  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int ITEM_TARGET   = 1700;
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_mode_e;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             op_i;
  logic [PIX_W-1:0] red_in_i;
  logic [PIX_W-1:0] green_in_i;
  logic [PIX_W-1:0] blue_in_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [PIX_W-1:0] red_out_o;
  logic [PIX_W-1:0] green_out_o;
  logic [PIX_W-1:0] blue_out_o;
  logic             frame_last_o;
  logic             cfg_we_i;
  logic [1:0]       cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  int         mismatch_cnt;
  int         pending_cnt;
  int         cycle_cnt = 0;
  int         hold_req = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  int         rx_wait = 0;
  int         items_sent = 0;
  idle_mode_e tx_mode = IDLE_FULL;
  idle_mode_e rx_mode = IDLE_FULL;

  rgb_box_blur_unsharp_mask_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .red_in_i     (red_in_i),
    .green_in_i   (green_in_i),
    .blue_in_i    (blue_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o),
    .frame_last_o (frame_last_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  unsharp_result_monitor monitor (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .op_i           (op_i),
    .red_i          (red_in_i),
    .green_i        (green_in_i),
    .blue_i         (blue_in_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .res_red_i      (red_out_o),
    .res_green_i    (green_out_o),
    .res_blue_i     (blue_out_o),
    .res_last_i     (frame_last_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int idle_draw(idle_mode_e m);
    case (m)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, 18);
      default:   return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] pick_level();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return PIX_W'(PIX_MAX);
      default: return PIX_W'($urandom_range(0, PIX_MAX));
    endcase
  endfunction

  // The receiver stalls for a drawn number of cycles after every accepted word,
  // and for a long stretch whenever a hold is requested.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) rx_wait = idle_draw(rx_mode);
      @(negedge clk_i);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic push_word(op_e op, logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                           logic [PIX_W-1:0] b);
    int gap;
    gap = idle_draw(tx_mode);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    red_in_i <= r;
    green_in_i <= g;
    blue_in_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic push_random(op_e op);
    push_word(op, pick_level(), pick_level(), pick_level());
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_cnt != 0 || hold_left != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Sends the first pixels of a frame and leaves the rest for the next size
  // write to abandon.
  task automatic run_cut(logic [CFG_W-1:0] wv, logic [CFG_W-1:0] hv,
                         logic [CFG_W-1:0] av, int count);
    settle();
    write_reg(REG_FRAME_WIDTH, wv);
    write_reg(REG_FRAME_HEIGHT, hv);
    write_reg(REG_SHARPEN_AMOUNT, av);
    for (int p = 0; p < count; p++) begin
      push_random(OP_PIXEL);
      items_sent++;
    end
  endtask

  // Sends whole frames, each followed by its flush words; the last frame may be
  // cut short and left for the next size write to abandon.
  task automatic run_phase(logic [CFG_W-1:0] wv, logic [CFG_W-1:0] hv,
                           logic [CFG_W-1:0] av, int frames, bit counted, bit squeeze);
    int w, h, n, cut, regain;
    settle();
    write_reg(REG_FRAME_WIDTH, wv);
    write_reg(REG_FRAME_HEIGHT, hv);
    write_reg(REG_SHARPEN_AMOUNT, av);
    if (squeeze) begin
      @(posedge clk_i);
      hold_req++;
      @(negedge clk_i);
    end
    w = (wv == '0) ? 1 : ((wv > MAX_WIDTH) ? MAX_WIDTH : wv);
    h = (hv == '0) ? 1 : ((hv > MAX_HEIGHT) ? MAX_HEIGHT : hv);
    for (int f = 0; f < frames; f++) begin
      n = w * h;
      cut = (f == frames - 1 && $urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : n;
      regain = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : -1;
      for (int p = 0; p < cut; p++) begin
        if (p == regain) begin
          settle();
          write_reg(REG_SHARPEN_AMOUNT, CFG_W'($urandom_range(0, 4095)));
        end
        if ($urandom_range(0, 39) == 0) push_random(OP_DRAIN);
        push_random(OP_PIXEL);
        if (counted) items_sent++;
      end
      if (cut < n) return;
      for (int d = 0; d <= w; d++) begin
        push_random(op_e'($urandom_range(0, 1)));
        if (counted) items_sent++;
      end
      if ($urandom_range(0, 7) == 0) push_random(OP_DRAIN);
    end
  endtask

  function automatic logic [CFG_W-1:0] pick_dim(int lo, int hi);
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return CFG_W'($urandom_range(1, MIN_DIM - 1));
      default: return CFG_W'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return CFG_W'(1 << FRAC_BITS);
      3:       return RST_SHARPEN_AMOUNT;
      default: return CFG_W'($urandom_range(0, 4095));
    endcase
  endfunction

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    op_i = OP_PIXEL;
    red_in_i = '0;
    green_in_i = '0;
    blue_in_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_FRAME_WIDTH;
    cfg_wdata_i = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // A one-pixel frame: an early drain is ignored, then a pixel after the
    // frame end flushes like a drain.
    write_reg(REG_SPARE, CFG_W'($urandom_range(0, 4095)));
    write_reg(REG_FRAME_WIDTH, '0);
    write_reg(REG_FRAME_HEIGHT, '0);
    write_reg(REG_SHARPEN_AMOUNT, '1);
    push_word(OP_DRAIN, 8'hA5, 8'h5A, 8'hC3);
    push_word(OP_PIXEL, 8'hFF, 8'h00, 8'h5A);
    push_word(OP_PIXEL, 8'h00, 8'hFF, 8'h33);
    push_word(OP_DRAIN, 8'h00, 8'h00, 8'h00);
    settle();

    // A 4x4 checkerboard at full gain drives the interior into both clamps.
    write_reg(REG_FRAME_WIDTH, CFG_W'(4));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(4));
    for (int i = 0; i < 16; i++) begin
      if (((i / 4) + (i % 4)) % 2 == 1) push_word(OP_PIXEL, 8'hFF, 8'h00, 8'hF0);
      else push_word(OP_PIXEL, 8'h00, 8'hFF, 8'h0F);
      if (i == 5) push_word(OP_DRAIN, 8'hFF, 8'hFF, 8'hFF);
    end
    for (int d = 0; d < 5; d++) begin
      push_word((d % 2 == 1) ? OP_PIXEL : OP_DRAIN, 8'h81, 8'h7E, 8'h18);
    end

    tx_mode = IDLE_SPARSE;
    rx_mode = IDLE_SPARSE;
    run_cut('1, CFG_W'(1), '0, 64);
    run_cut(CFG_W'(1), '1, '1, 96);
    run_cut(CFG_W'(MAX_WIDTH), CFG_W'(4), '1, 64);

    tx_mode = IDLE_NONE;
    rx_mode = IDLE_NONE;
    run_phase(CFG_W'(8), CFG_W'(8), RST_SHARPEN_AMOUNT, 2, 1'b1, 1'b1);

    while (items_sent < ITEM_TARGET) begin
      tx_mode = idle_mode_e'($urandom_range(0, 2));
      rx_mode = idle_mode_e'($urandom_range(0, 2));
      run_phase(pick_dim(MIN_DIM, 16), pick_dim(MIN_DIM, 10), pick_gain(),
                $urandom_range(1, 3), 1'b1, 1'b0);
    end

    settle();
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ rgb_box_blur_unsharp_mask_unit.f @@
+incdir+rtl
rtl/rbum_pkg.sv
rtl/rbum_line_window.sv
rtl/rbum_sharpen_pipe.sv
rtl/rgb_box_blur_unsharp_mask_unit.sv
verif/unsharp_result_monitor.sv
verif/tb.sv
